>>> src/lsb_stego_stream_decoder_assert.svh
// Assertion macros for the LSB stego stream decoder checker.
// Expects clk and arst_n in the scope of use.
`ifndef LSB_STEGO_STREAM_DECODER_ASSERT_SVH
`define LSB_STEGO_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define LSBSD_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// next-cycle implication
`define LSBSD_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

>>> src/lsbsd_pkg.sv
// Shared types and constants of the LSB stego stream decoder.
// No dependencies.
package lsbsd_pkg;

	localparam int MAX_MAGIC_CHARS = 8;
	localparam int SIZE_FIELD_BITS = 32;
	localparam int BYTE_BITS       = 8;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int PADDR_W         = 5;

	localparam logic [7:0] HEADER_BYTES_RESET = 8'd54;
	localparam logic [3:0] MAGIC_LENGTH_RESET = 4'd2;

	localparam logic [1:0] REG_HEADER_BYTES   = 2'd0;
	localparam logic [1:0] REG_MAGIC_LENGTH   = 2'd1;
	localparam logic [1:0] REG_EXPECTED_MAGIC = 2'd2;

	localparam logic [2:0] KIND_EXT_LENGTH    = 3'd0;
	localparam logic [2:0] KIND_EXT_CHAR      = 3'd1;
	localparam logic [2:0] KIND_PAYLOAD_SIZE  = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD_BYTE  = 3'd3;
	localparam logic [2:0] KIND_MAGIC_MISMATCH = 3'd4;
	localparam logic [2:0] KIND_TRUNCATED     = 3'd5;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       end_of_image;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic        end_of_run;
		logic        decode_done;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  header_bytes;
		logic [3:0]  magic_length;
		logic [63:0] expected_magic;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic        decode_done;
	} res_t;

	// one queue entry: the results of one item, one or two of them
	typedef struct packed {
		logic two;
		res_t res0;
		res_t res1;
	} entry_t;

endpackage

>>> src/lsbsd_front.sv
// Front end: accepts image bytes, tracks the decoding phase and classifies results.
// Depends on lsbsd_pkg.
module lsbsd_front import lsbsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     image_valid,
	input  in_item_t image_item,
	input  logic     queue_full,
	output logic     push,
	output entry_t   push_entry
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_MAGIC  = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_EXTCHR = 3'd3;
	localparam logic [2:0] PH_SIZE   = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	logic [2:0]  phase_q, ph;
	logic [7:0]  hdr_cnt_q, hdr_n;
	logic [4:0]  bit_cnt_q, bc_n;
	logic [31:0] shift_q, sh_n, sh;
	logic [31:0] field_cnt_q, fc_n, fc_inc;
	logic [31:0] ext_len_q, ext_n;
	logic [31:0] pay_size_q, pay_n;
	logic        mismatch_q, mm_n;
	logic        accept, use_bit, need32, unit_ok, trunc;
	logic [5:0]  bc_inc;
	logic [3:0]  mag_chars;
	logic [2:0]  magic_idx;
	logic [7:0]  magic_exp;
	res_t        res_unit, res_trunc;

	assign accept = image_valid && !queue_full;
	assign sh     = {shift_q[30:0], image_item.image_byte[0]};
	assign bc_inc = {1'b0, bit_cnt_q} + 6'd1;
	assign fc_inc = field_cnt_q + 32'd1;

	always_comb begin
		if (cfg.magic_length == 4'd0)
			mag_chars = 4'd1;
		else if (cfg.magic_length > 4'(MAX_MAGIC_CHARS))
			mag_chars = 4'(MAX_MAGIC_CHARS);
		else
			mag_chars = cfg.magic_length;
	end

	assign magic_idx = mag_chars[2:0] - 3'd1 - field_cnt_q[2:0];
	assign magic_exp = cfg.expected_magic[{magic_idx, 3'b000} +: 8];

	always_comb begin
		ph       = phase_q;
		hdr_n    = hdr_cnt_q;
		bc_n     = bit_cnt_q;
		sh_n     = shift_q;
		fc_n     = field_cnt_q;
		ext_n    = ext_len_q;
		pay_n    = pay_size_q;
		mm_n     = mismatch_q;
		use_bit  = 1'b1;
		unit_ok  = 1'b0;
		res_unit = '0;

		if (ph == PH_HEADER) begin
			if (hdr_cnt_q < cfg.header_bytes) begin
				hdr_n   = hdr_cnt_q + 8'd1;
				use_bit = 1'b0;
			end else begin
				ph = PH_MAGIC;
			end
		end
		if (ph == PH_DONE)
			use_bit = 1'b0;
		need32 = (ph == PH_EXTLEN) || (ph == PH_SIZE);

		if (use_bit) begin
			if (bc_inc >= (need32 ? 6'(SIZE_FIELD_BITS) : 6'(BYTE_BITS))) begin
				sh_n = '0;
				bc_n = '0;
				unique case (ph)
					PH_MAGIC: begin
						mm_n = mismatch_q || (sh[7:0] != magic_exp);
						fc_n = fc_inc;
						if (fc_inc >= {28'd0, mag_chars}) begin
							fc_n = '0;
							if (mm_n) begin
								unit_ok  = 1'b1;
								res_unit = '{kind: KIND_MAGIC_MISMATCH, value: '0,
									decode_done: 1'b1};
								ph = PH_DONE;
							end else begin
								ph = PH_EXTLEN;
							end
						end
					end
					PH_EXTLEN: begin
						ext_n    = sh[31] ? '0 : sh;
						unit_ok  = 1'b1;
						res_unit = '{kind: KIND_EXT_LENGTH, value: sh, decode_done: 1'b0};
						fc_n     = '0;
						ph       = (ext_n == '0) ? PH_SIZE : PH_EXTCHR;
					end
					PH_EXTCHR: begin
						unit_ok  = 1'b1;
						res_unit = '{kind: KIND_EXT_CHAR, value: {24'd0, sh[7:0]},
							decode_done: 1'b0};
						fc_n     = fc_inc;
						if (fc_inc >= ext_len_q) begin
							fc_n = '0;
							ph   = PH_SIZE;
						end
					end
					PH_SIZE: begin
						pay_n    = sh;
						fc_n     = '0;
						unit_ok  = 1'b1;
						res_unit = '{kind: KIND_PAYLOAD_SIZE, value: sh,
							decode_done: (sh == '0)};
						ph       = (sh == '0) ? PH_DONE : PH_DATA;
					end
					PH_DATA: begin
						fc_n     = fc_inc;
						unit_ok  = 1'b1;
						res_unit = '{kind: KIND_PAYLOAD_BYTE, value: {24'd0, sh[7:0]},
							decode_done: (fc_inc == pay_size_q)};
						if (fc_inc == pay_size_q)
							ph = PH_DONE;
					end
					default: ;
				endcase
			end else begin
				sh_n = sh;
				bc_n = bc_inc[4:0];
			end
		end

		trunc = image_item.end_of_image && (ph != PH_DONE);
		if (image_item.end_of_image) begin
			ph    = PH_HEADER;
			hdr_n = '0;
			bc_n  = '0;
			sh_n  = '0;
			fc_n  = '0;
			ext_n = '0;
			pay_n = '0;
			mm_n  = 1'b0;
		end
	end

	assign res_trunc = '{kind: KIND_TRUNCATED, value: '0, decode_done: 1'b1};

	assign push            = accept && (unit_ok || trunc);
	assign push_entry.two  = unit_ok && trunc;
	assign push_entry.res0 = unit_ok ? res_unit : res_trunc;
	assign push_entry.res1 = res_trunc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			field_cnt_q <= '0;
			ext_len_q   <= '0;
			pay_size_q  <= '0;
			mismatch_q  <= 1'b0;
		end else if (accept) begin
			phase_q     <= ph;
			hdr_cnt_q   <= hdr_n;
			bit_cnt_q   <= bc_n;
			shift_q     <= sh_n;
			field_cnt_q <= fc_n;
			ext_len_q   <= ext_n;
			pay_size_q  <= pay_n;
			mismatch_q  <= mm_n;
		end
	end

endmodule

>>> src/lsbsd_queue.sv
// Small FIFO of result entries between front and back.
// Depends on lsbsd_pkg.
module lsbsd_queue import lsbsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output entry_t head
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

>>> src/lsbsd_back.sv
// Back end: unpacks queue entries into single result items behind an output register.
// Depends on lsbsd_pkg.
module lsbsd_back import lsbsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      not_empty,
	input  entry_t    head,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	logic      out_valid_q;
	out_item_t out_q;
	logic      idx_q;
	logic      load, last;
	res_t      sel;

	assign load = (!out_valid_q || !result_stall) && not_empty;
	assign last = !head.two || idx_q;
	assign sel  = idx_q ? head.res1 : head.res0;
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= !last;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= '{kind: sel.kind, value: sel.value, end_of_run: last,
				decode_done: sel.decode_done};
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

endmodule

>>> src/lsb_stego_stream_decoder.sv
// Top level of the LSB stego stream decoder: config registers, front, queue, back.
// Depends on lsbsd_pkg, lsbsd_front, lsbsd_queue, lsbsd_back.
//
// Usage:
//  image channel (image_valid/image_stall/image_item) takes one image file byte per
//  item; end_of_image marks the last byte and the next byte starts a new image.
//  result channel (result_valid/result_stall/result_item) gives the decoded length,
//  size, character and byte items, plus mismatch and truncation flags.
//  An item is taken at a rising edge with valid high and stall low.
//  Registers sit at byte addresses 0 (header_bytes), 8 (magic_length) and
//  16 (expected_magic) of the 64-bit APB port; write them only while idle.
//  The first result of an item passes through the queue and then the output
//  register before it is shown.
//  One image byte is taken per cycle while image_stall is low; an item with two
//  results gives them as two result items in turn. A four-entry queue separates
//  the decoder from the output register, so the image side keeps going while a
//  result waits. When the receiver stalls, the result holds and the queue fills;
//  image_stall rises once four entries wait.
//  Reset clears the decoding state, the queue and the output, and loads the
//  register defaults (54 header bytes, 2 magic characters, magic zero).
module lsb_stego_stream_decoder import lsbsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               image_valid,
	output logic               image_stall,
	input  in_item_t           image_item,
	output logic               result_valid,
	input  logic               result_stall,
	output out_item_t          result_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	cfg_t   cfg_q;
	logic   push, pop, full, not_empty;
	entry_t push_entry, head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_bytes   <= HEADER_BYTES_RESET;
			cfg_q.magic_length   <= MAGIC_LENGTH_RESET;
			cfg_q.expected_magic <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:3])
				REG_HEADER_BYTES:   cfg_q.header_bytes   <= pwdata[7:0];
				REG_MAGIC_LENGTH:   cfg_q.magic_length   <= pwdata[3:0];
				REG_EXPECTED_MAGIC: cfg_q.expected_magic <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_HEADER_BYTES:   prdata = {56'd0, cfg_q.header_bytes};
			REG_MAGIC_LENGTH:   prdata = {60'd0, cfg_q.magic_length};
			REG_EXPECTED_MAGIC: prdata = cfg_q.expected_magic;
			default:            prdata = '0;
		endcase
	end

	assign image_stall = full;

	lsbsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.image_valid(image_valid),
		.image_item (image_item),
		.queue_full (full),
		.push       (push),
		.push_entry (push_entry)
	);

	lsbsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	lsbsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (not_empty),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

endmodule

>>> src/lsbsd_checker.sv
// Port-level checker of the LSB stego stream decoder, bound to the top level.
// Depends on lsbsd_pkg and lsb_stego_stream_decoder_assert.svh.
`include "lsb_stego_stream_decoder_assert.svh"

module lsbsd_checker import lsbsd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result_item
);

	`LSBSD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_item), "stalled result item changed")
	`LSBSD_ASSERT_NOW(a_done_ends_run, result_valid && result_item.decode_done, result_item.end_of_run, "decode_done without end_of_run")
	`LSBSD_ASSERT_NOW(a_flag_value, result_valid && (result_item.kind == KIND_MAGIC_MISMATCH || result_item.kind == KIND_TRUNCATED), result_item.value == '0 && result_item.decode_done, "error item with value or not done")
	`LSBSD_ASSERT_NOW(a_byte_value, result_valid && (result_item.kind == KIND_EXT_CHAR || result_item.kind == KIND_PAYLOAD_BYTE), result_item.value[31:8] == '0, "character item wider than a byte")

endmodule

bind lsb_stego_stream_decoder lsbsd_checker u_lsbsd_checker (.*);

>>> sim/tb_lsb_stego_stream_decoder.sv
// Self-checking bench for lsb_stego_stream_decoder: drives image bytes with hidden
// LSB fields, predicts decoded results internally and checks each result item.
// Depends on lsbsd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_lsb_stego_stream_decoder;
	import lsbsd_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 10;
	localparam int NUM_PHASES   = 4;

	typedef enum logic [2:0] {
		DP_HEADER, DP_MAGIC, DP_EXTLEN, DP_EXTCHR, DP_SIZE, DP_DATA, DP_DONE
	} dec_phase_e;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               image_valid  = 1'b0;
	logic               image_stall;
	in_item_t           image_item   = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	out_item_t          result_item;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [63:0]        pwdata       = '0;
	logic [63:0]        prdata;
	logic               pready;

	lsb_stego_stream_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_valid  (image_valid),
		.image_stall  (image_stall),
		.image_item   (image_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// decoder shadow: registers and decoding state
	logic [7:0]  m_header_bytes;
	logic [3:0]  m_magic_length;
	logic [63:0] m_expected_magic;
	dec_phase_e  m_phase;
	int unsigned m_header_count;
	int unsigned m_bit_count;
	logic [31:0] m_bit_shift;
	int unsigned m_field_count;
	logic [31:0] m_ext_length;
	logic [31:0] m_payload_size;
	logic        m_mismatch;

	in_item_t  pending_items[$];
	in_item_t  build_q[$];
	out_item_t expected_results[$];
	out_item_t oldest;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        errors         = 0;
	int        phase_bytes    = 0;
	int        quiet_cycles   = 0;

	function automatic int unsigned magic_chars();
		int unsigned m;
		m = m_magic_length;
		if (m < 1) m = 1;
		if (m > MAX_MAGIC_CHARS) m = MAX_MAGIC_CHARS;
		return m;
	endfunction

	function automatic out_item_t mk_result(logic [2:0] kind, logic [31:0] value, logic done);
		out_item_t r;
		r.kind        = kind;
		r.value       = value;
		r.end_of_run  = 1'b0;
		r.decode_done = done;
		return r;
	endfunction

	task automatic clear_decode();
		m_phase        = DP_HEADER;
		m_header_count = 0;
		m_bit_count    = 0;
		m_bit_shift    = '0;
		m_field_count  = 0;
		m_ext_length   = '0;
		m_payload_size = '0;
		m_mismatch     = 1'b0;
	endtask

	task automatic predict_item(in_item_t it);
		out_item_t   found[$];
		logic        data;
		int unsigned need;
		int unsigned len;
		logic [31:0] unit;
		logic [7:0]  want;
		data = 1'b1;
		if (m_phase == DP_HEADER) begin
			if (m_header_count < m_header_bytes) begin
				m_header_count++;
				data = 1'b0;
			end else begin
				m_phase = DP_MAGIC;
			end
		end
		if (m_phase == DP_DONE) data = 1'b0;
		if (data) begin
			need = (m_phase == DP_EXTLEN || m_phase == DP_SIZE) ? SIZE_FIELD_BITS : BYTE_BITS;
			m_bit_shift = {m_bit_shift[30:0], it.image_byte[0]};
			m_bit_count++;
			if (m_bit_count >= need) begin
				unit = m_bit_shift;
				m_bit_shift = '0;
				m_bit_count = 0;
				case (m_phase)
					DP_MAGIC: begin
						len  = magic_chars();
						want = 8'(m_expected_magic >> (8 * ((len - 1 - m_field_count) & 7)));
						if (unit[7:0] != want) m_mismatch = 1'b1;
						m_field_count++;
						if (m_field_count >= len) begin
							m_field_count = 0;
							if (m_mismatch) begin
								found.push_back(mk_result(KIND_MAGIC_MISMATCH, '0, 1'b1));
								m_phase = DP_DONE;
							end else begin
								m_phase = DP_EXTLEN;
							end
						end
					end
					DP_EXTLEN: begin
						m_ext_length = unit[31] ? 32'd0 : unit;
						found.push_back(mk_result(KIND_EXT_LENGTH, unit, 1'b0));
						m_field_count = 0;
						m_phase = (m_ext_length == 0) ? DP_SIZE : DP_EXTCHR;
					end
					DP_EXTCHR: begin
						found.push_back(mk_result(KIND_EXT_CHAR, {24'd0, unit[7:0]}, 1'b0));
						m_field_count++;
						if (m_field_count >= m_ext_length) begin
							m_field_count = 0;
							m_phase = DP_SIZE;
						end
					end
					DP_SIZE: begin
						m_payload_size = unit;
						m_field_count = 0;
						found.push_back(mk_result(KIND_PAYLOAD_SIZE, unit, unit == 0));
						m_phase = (unit == 0) ? DP_DONE : DP_DATA;
					end
					DP_DATA: begin
						m_field_count++;
						found.push_back(mk_result(KIND_PAYLOAD_BYTE, {24'd0, unit[7:0]},
							m_field_count == m_payload_size));
						if (m_field_count == m_payload_size) m_phase = DP_DONE;
					end
					default: ;
				endcase
			end
		end
		if (it.end_of_image) begin
			if (m_phase != DP_DONE) found.push_back(mk_result(KIND_TRUNCATED, '0, 1'b1));
			clear_decode();
		end
		if (found.size() != 0) found[found.size() - 1].end_of_run = 1'b1;
		foreach (found[i]) expected_results.push_back(found[i]);
	endtask

	// image byte driver
	always @(posedge clk) begin
		if (image_valid && !image_stall) predict_item(image_item);
		if (!image_valid || !image_stall) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				image_valid <= 1'b1;
				image_item  <= pending_items.pop_front();
			end else begin
				image_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result item: kind %0d value %0h", result_item.kind,
					result_item.value);
				errors++;
			end else begin
				oldest = expected_results.pop_front();
				if (result_item.kind != oldest.kind) begin
					$error("kind: expected %0d actual %0d", oldest.kind, result_item.kind);
					errors++;
				end
				if (result_item.value != oldest.value) begin
					$error("value: expected %0h actual %0h", oldest.value, result_item.value);
					errors++;
				end
				if (result_item.end_of_run != oldest.end_of_run) begin
					$error("end_of_run: expected %0b actual %0b", oldest.end_of_run,
						result_item.end_of_run);
					errors++;
				end
				if (result_item.decode_done != oldest.decode_done) begin
					$error("decode_done: expected %0b actual %0b", oldest.decode_done,
						result_item.decode_done);
					errors++;
				end
			end
		end
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((image_valid && !image_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(8 * idx);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_HEADER_BYTES:   m_header_bytes   = val[7:0];
			REG_MAGIC_LENGTH:   m_magic_length   = val[3:0];
			REG_EXPECTED_MAGIC: m_expected_magic = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || image_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic hide_bits(input logic [31:0] val, input int nbits);
		in_item_t b;
		for (int i = nbits - 1; i >= 0; i--) begin
			b.image_byte   = {7'($urandom), val[i]};
			b.end_of_image = 1'b0;
			build_q.push_back(b);
		end
	endtask

	task automatic flush_image();
		build_q[build_q.size() - 1].end_of_image = 1'b1;
		foreach (build_q[i]) pending_items.push_back(build_q[i]);
		phase_bytes += build_q.size();
		build_q.delete();
	endtask

	// cut = 0 keeps the whole image, else only its first cut bytes
	task automatic make_image(input bit bad_magic, input logic [31:0] ext_len,
			input logic [31:0] size, input int cut, input int trailer);
		int unsigned mlen;
		int          bad_at;
		logic [7:0]  ch;
		int          n_ext;
		int          n_pay;
		mlen   = magic_chars();
		bad_at = $urandom_range(mlen - 1);
		repeat (m_header_bytes) hide_bits($urandom, 1);
		for (int k = 0; k < mlen; k++) begin
			ch = 8'(m_expected_magic >> (8 * (mlen - 1 - k)));
			if (bad_magic && k == bad_at) ch ^= 8'($urandom_range(255, 1));
			hide_bits({24'd0, ch}, 8);
		end
		if (!bad_magic) begin
			hide_bits(ext_len, 32);
			n_ext = ext_len[31] ? 0 : int'(ext_len);
			repeat (n_ext) hide_bits($urandom, 8);
			hide_bits(size, 32);
			n_pay = (size > 8) ? 8 : int'(size);
			repeat (n_pay) hide_bits($urandom, 8);
		end
		repeat (trailer) hide_bits($urandom, 1);
		if (cut > 0)
			while (build_q.size() > cut) void'(build_q.pop_back());
		flush_image();
	endtask

	task automatic random_image();
		int          r;
		logic [31:0] ext_len;
		logic [31:0] size;
		int          trail;
		r = $urandom_range(99);
		if (r < 25) ext_len = 0;
		else if (r < 40) ext_len = {1'b1, 31'($urandom)};
		else ext_len = $urandom_range(3, 1);
		r = $urandom_range(99);
		if (r < 20) size = 0;
		else if (r < 30) size = $urandom | 32'h0000_0100;
		else size = $urandom_range(4, 1);
		trail = ($urandom_range(99) < 40) ? 0 : $urandom_range(3, 1);
		r = $urandom_range(99);
		if (r < 72) make_image(1'b0, ext_len, size, 0, trail);
		else if (r < 86) make_image(1'b1, ext_len, size, 0, trail);
		else make_image(1'b0, ext_len, size, $urandom_range(90, 1), trail);
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
		endcase
	endtask

	initial begin
		logic [7:0]  hdr;
		logic [3:0]  mlen;
		logic [63:0] magic;
		m_header_bytes   = HEADER_BYTES_RESET;
		m_magic_length   = MAGIC_LENGTH_RESET;
		m_expected_magic = '0;
		clear_decode();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: image ends on its first byte, then inside the header
		build_q.push_back(in_item_t'{8'hFF, 1'b0});
		flush_image();
		build_q.push_back(in_item_t'{8'h00, 1'b0});
		build_q.push_back(in_item_t'{8'hFF, 1'b0});
		build_q.push_back(in_item_t'{8'h01, 1'b0});
		flush_image();
		wait_drained();

		write_reg(REG_HEADER_BYTES, 64'd0);
		write_reg(REG_MAGIC_LENGTH, 64'd1);
		write_reg(REG_EXPECTED_MAGIC, 64'h0123_4567_89AB_CDA5);
		// wrong magic, then bytes that must be ignored
		hide_bits(32'h5A, 8);
		hide_bits(32'h3, 2);
		flush_image();
		// right magic, image ends inside the extension length
		hide_bits(32'hA5, 8);
		hide_bits(32'h0, 4);
		flush_image();
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin hdr = 8'd0;   mlen = 4'd1;  magic = {$urandom, $urandom}; end
				1: begin hdr = 8'd255; mlen = 4'd1;  magic = '1; end
				2: begin hdr = 8'd2;   mlen = 4'd0;  magic = '0; end
				3: begin hdr = 8'd1;   mlen = 4'd15; magic = {$urandom, $urandom}; end
				4: begin hdr = 8'd0;   mlen = 4'd8;  magic = {$urandom, $urandom}; end
				default: begin
					hdr   = 8'($urandom_range(6));
					mlen  = 4'($urandom_range(8, 1));
					magic = {$urandom, $urandom};
				end
			endcase
			write_reg(REG_HEADER_BYTES, {56'd0, hdr});
			write_reg(REG_MAGIC_LENGTH, {60'd0, mlen});
			write_reg(REG_EXPECTED_MAGIC, magic);
			set_idle(p % 4);
			phase_bytes = 0;
			if (p == 0) begin
				make_image(1'b0, 32'd0, 32'd0, 0, 2);
				make_image(1'b0, 32'h8000_0003, 32'd1, 0, 0);
				make_image(1'b0, 32'd2, 32'd3, 0, 1);
			end else begin
				random_image();
			end
			while (phase_bytes < 70) random_image();
			wait_drained();
		end

		if (errors == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/lsbsd_pkg.sv
src/lsbsd_front.sv
src/lsbsd_queue.sv
src/lsbsd_back.sv
src/lsb_stego_stream_decoder.sv
src/lsbsd_checker.sv
sim/tb_lsb_stego_stream_decoder.sv
